>>> rtl/e2q_pkg.sv
// e2q_pkg: shared types and constants for the Euler-to-quaternion unit.
// Holds the channel structs, the CORDIC iteration count, the gain and the arctangent table.
// No dependencies.
package e2q_pkg;

  localparam int CORDIC_ITERS = 30;

  // 1/K in Q2.30; preloads x so the rotation needs no gain correction
  localparam logic signed [31:0] CORDIC_GAIN_INV = 32'sd652032874;

  // atan(2^-i), 2^32 = one full turn
  localparam logic [31:0] ATAN_TABLE [CORDIC_ITERS] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
    32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F,
    32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
    32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001
  };

  typedef struct packed {
    logic signed [15:0] pitch_angle;
    logic signed [15:0] yaw_angle;
    logic signed [15:0] roll_angle;
  } e2q_in_t;

  typedef struct packed {
    logic signed [15:0] quat_x;
    logic signed [15:0] quat_y;
    logic signed [15:0] quat_z;
    logic signed [15:0] quat_w;
  } e2q_out_t;

  // Q2.30 product, rounded half up
  function automatic logic signed [31:0] q30_mul(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
    logic signed [63:0] p;
    p = 64'(a) * 64'(b) + (64'sd1 <<< 29);
    return p[61:30];
  endfunction

endpackage

>>> rtl/e2q_cordic.sv
// e2q_cordic: rotation-mode CORDIC, one iteration per register stage.
// Depends on e2q_pkg (iteration count, gain, arctangent table).
module e2q_cordic (
  input  logic                                clk,
  input  logic [e2q_pkg::CORDIC_ITERS-1:0]    en,
  input  logic signed [31:0]                  phase,
  output logic signed [31:0]                  cos_q,
  output logic signed [31:0]                  sin_q
);
  import e2q_pkg::*;

  logic signed [33:0] x_r [CORDIC_ITERS];
  logic signed [33:0] y_r [CORDIC_ITERS];
  logic signed [33:0] z_r [CORDIC_ITERS];

  for (genvar i = 0; i < CORDIC_ITERS; i++) begin : g_it
    logic signed [33:0] xi, yi, zi, x_nxt, y_nxt, z_nxt;
    logic signed [33:0] at;

    if (i == 0) begin : g_first
      assign xi = 34'(CORDIC_GAIN_INV);
      assign yi = '0;
      assign zi = 34'(phase);
    end else begin : g_next
      assign xi = x_r[i-1];
      assign yi = y_r[i-1];
      assign zi = z_r[i-1];
    end

    assign at = $signed({2'b00, ATAN_TABLE[i]});

    always_comb begin
      if (!zi[33]) begin
        x_nxt = xi - (yi >>> i);
        y_nxt = yi + (xi >>> i);
        z_nxt = zi - at;
      end else begin
        x_nxt = xi + (yi >>> i);
        y_nxt = yi - (xi >>> i);
        z_nxt = zi + at;
      end
    end

    always_ff @(posedge clk) begin
      if (en[i]) begin
        x_r[i] <= x_nxt;
        y_r[i] <= y_nxt;
        z_r[i] <= z_nxt;
      end
    end
  end

  assign cos_q = x_r[CORDIC_ITERS-1][31:0];
  assign sin_q = y_r[CORDIC_ITERS-1][31:0];

endmodule

>>> rtl/e2q_combine.sv
// e2q_combine: two product stages forming the triple products of the quaternion terms.
// Depends on e2q_pkg (q30_mul).
module e2q_combine (
  input  logic               clk,
  input  logic [1:0]         en,
  input  logic signed [31:0] cp,
  input  logic signed [31:0] sp,
  input  logic signed [31:0] cy,
  input  logic signed [31:0] sy,
  input  logic signed [31:0] cr,
  input  logic signed [31:0] sr,
  output logic signed [31:0] prod [8]
);
  import e2q_pkg::*;

  logic signed [31:0] cpcy_r, spsy_r, cpsy_r, spcy_r, cr_r, sr_r;
  logic signed [31:0] prod_r [8];

  always_ff @(posedge clk) begin
    if (en[0]) begin
      cpcy_r <= q30_mul(cp, cy);
      spsy_r <= q30_mul(sp, sy);
      cpsy_r <= q30_mul(cp, sy);
      spcy_r <= q30_mul(sp, cy);
      cr_r   <= cr;
      sr_r   <= sr;
    end
  end

  // pairs: x = 0-1, y = 2+3, z = 4-5, w = 6+7
  always_ff @(posedge clk) begin
    if (en[1]) begin
      prod_r[0] <= q30_mul(sr_r, cpcy_r);
      prod_r[1] <= q30_mul(cr_r, spsy_r);
      prod_r[2] <= q30_mul(cr_r, spcy_r);
      prod_r[3] <= q30_mul(sr_r, cpsy_r);
      prod_r[4] <= q30_mul(cr_r, cpsy_r);
      prod_r[5] <= q30_mul(sr_r, spcy_r);
      prod_r[6] <= q30_mul(cr_r, cpcy_r);
      prod_r[7] <= q30_mul(sr_r, spsy_r);
    end
  end

  assign prod = prod_r;

endmodule

>>> rtl/euler_to_quaternion_unit.sv
// euler_to_quaternion_unit: ZYX Euler angles to unit quaternion, fully pipelined.
// Depends on e2q_pkg, e2q_cordic and e2q_combine.
//
//  channel  ports                       payload      direction
//  input    in_valid in_stall in_data   e2q_in_t     pitch, yaw, roll binary angles
//  output   out_valid out_stall out_data e2q_out_t   quaternion x, y, z, w in Q1.15
//
// One transfer per cycle sustained while out_stall is low; the pipeline is 30 CORDIC
// iterations (one per stage), two product stages and one round/saturate stage.
// Each stage carries a valid bit and loads whenever it is empty or its
// content moves on, so bubbles collapse behind a stalled output and the
// input keeps taking transfers until every stage holds an item.
// rst_n (synchronous) clears the valid bits only; the datapath has no reset.
module euler_to_quaternion_unit #(
  parameter int ANGLE_BITS = 16,
  parameter int FRAC_BITS  = 15
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  e2q_pkg::e2q_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output e2q_pkg::e2q_out_t out_data
);
  import e2q_pkg::*;

  localparam int NST = CORDIC_ITERS + 3;
  localparam int SH  = (FRAC_BITS <= 30) ? 30 - FRAC_BITS : 0;
  localparam int UP  = (FRAC_BITS > 30) ? FRAC_BITS - 30 : 0;
  localparam logic signed [39:0] RND = (SH > 0) ? (40'sd1 <<< (SH - 1)) : 40'sd0;
  localparam logic signed [39:0] SAT_HI = (40'sd1 <<< FRAC_BITS) - 40'sd1;
  localparam logic signed [39:0] SAT_LO = -(40'sd1 <<< FRAC_BITS);

  // valid bit per stage, ready chain from the output back
  logic [NST-1:0] v_r;
  logic [NST:0]   rdy;

  assign rdy[NST] = !out_stall;
  for (genvar k = 0; k < NST; k++) begin : g_rdy
    assign rdy[k] = !v_r[k] || rdy[k+1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (rdy[0]) v_r[0] <= in_valid;
      for (int k = 1; k < NST; k++) begin
        if (rdy[k]) v_r[k] <= v_r[k-1];
      end
    end
  end

  assign in_stall  = !rdy[0];
  assign out_valid = v_r[NST-1];

  // half angle as a 32-bit phase: take the low ANGLE_BITS as a signed angle,
  // scale to 2^32/turn, halve
  logic [31:0]        raw [3];
  logic signed [31:0] phase [3];
  logic signed [31:0] c_q [3];
  logic signed [31:0] s_q [3];

  assign raw[0] = {16'b0, in_data.pitch_angle};
  assign raw[1] = {16'b0, in_data.yaw_angle};
  assign raw[2] = {16'b0, in_data.roll_angle};

  for (genvar a = 0; a < 3; a++) begin : g_lane
    assign phase[a] = $signed(raw[a] << (32 - ANGLE_BITS)) >>> 1;

    e2q_cordic u_cordic (
      .clk   (clk),
      .en    (rdy[CORDIC_ITERS-1:0]),
      .phase (phase[a]),
      .cos_q (c_q[a]),
      .sin_q (s_q[a])
    );
  end

  logic signed [31:0] prod [8];

  e2q_combine u_combine (
    .clk  (clk),
    .en   (rdy[CORDIC_ITERS+1:CORDIC_ITERS]),
    .cp   (c_q[0]),
    .sp   (s_q[0]),
    .cy   (c_q[1]),
    .sy   (s_q[1]),
    .cr   (c_q[2]),
    .sr   (s_q[2]),
    .prod (prod)
  );

  // final stage: pair sum, round half up to FRAC_BITS, saturate
  logic signed [39:0] sum [4];
  logic [15:0]        q [4];
  e2q_out_t           out_r;

  assign sum[0] = 40'(prod[0]) - 40'(prod[1]);
  assign sum[1] = 40'(prod[2]) + 40'(prod[3]);
  assign sum[2] = 40'(prod[4]) - 40'(prod[5]);
  assign sum[3] = 40'(prod[6]) + 40'(prod[7]);

  for (genvar j = 0; j < 4; j++) begin : g_out
    logic signed [39:0] r;
    always_comb begin
      r = ((sum[j] + RND) >>> SH) <<< UP;
      if (r > SAT_HI) r = SAT_HI;
      if (r < SAT_LO) r = SAT_LO;
      q[j] = r[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[NST-1]) begin
      out_r.quat_x <= q[0];
      out_r.quat_y <= q[1];
      out_r.quat_z <= q[2];
      out_r.quat_w <= q[3];
    end
  end

  assign out_data = out_r;

endmodule
